// ----- hw/rtl/rbb_pkg.sv -----
// Shared types, constants and register codes of the RGB box blur block.
`default_nettype none

package rbb_pkg;

    localparam int RADIUS_DEF    = 5;
    localparam int MAX_WIDTH_DEF = 1024;
    localparam int MAX_HEIGHT    = 4096;
    localparam int ROW_W         = 12;
    localparam int FH_W          = 13;
    localparam int FW_W          = 11;
    localparam int CFG_W         = 13;
    localparam int CFG_IDX_W     = 2;
    localparam int WIDTH_RESET   = 640;
    localparam int HEIGHT_RESET  = 480;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

    localparam logic OP_PIXEL = 1'b0;

    typedef struct packed {
        logic       op;
        logic [7:0] red_in;
        logic [7:0] green_in;
        logic [7:0] blue_in;
    } rbb_in_t;

    typedef struct packed {
        logic [7:0] red_out;
        logic [7:0] green_out;
        logic [7:0] blue_out;
        logic       frame_end;
    } rbb_out_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_COL,
        ST_CWAIT,
        ST_PUSH,
        ST_DSTART,
        ST_DIV,
        ST_OUT
    } rbb_state_t;

endpackage

`default_nettype wire

// ----- hw/rtl/rbb_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module rbb_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ----- hw/rtl/rbb_cell.sv -----
// One cell of the window chain: holds the three channel sums of one window column.
`default_nettype none

module rbb_cell #(
    parameter int CS_W = 12
) (
    input  wire logic                 clk,
    input  wire logic                 clear,
    input  wire logic                 shift,
    input  wire logic [2:0][CS_W-1:0] d_in,
    output logic      [2:0][CS_W-1:0] q
);

    logic [2:0][CS_W-1:0] data_reg;

    always_ff @(posedge clk) begin
        if (clear) begin
            data_reg <= '0;
        end else if (shift) begin
            data_reg <= d_in;
        end
    end

    assign q = data_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/rbb_div.sv -----
// Restoring divider that yields an 8-bit quotient, one bit per cycle.
`default_nettype none

module rbb_div #(
    parameter int SUM_W = 15,
    parameter int CNT_W = 7
) (
    input  wire logic             clk,
    input  wire logic             rstn,
    input  wire logic             start,
    input  wire logic [SUM_W-1:0] sum,
    input  wire logic [CNT_W-1:0] cnt,
    output logic                  busy,
    output logic      [7:0]       quot
);

    localparam int DW = SUM_W + 1;

    logic [DW-1:0] rem_reg;
    logic [DW-1:0] dvs_reg;
    logic [7:0]    q_reg;
    logic [2:0]    step_reg;
    logic          busy_reg;
    logic          ge;

    // The quotient is a mean and never exceeds 255, so eight steps suffice.
    assign ge = rem_reg >= dvs_reg;

    always_ff @(posedge clk) begin
        if (!rstn) begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            step_reg <= '0;
        end else if (busy_reg) begin
            step_reg <= step_reg + 3'd1;
            if (step_reg == 3'd7) begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk) begin
        if (start) begin
            rem_reg <= DW'(sum);
            dvs_reg <= DW'(cnt) << 7;
            q_reg   <= '0;
        end else if (busy_reg) begin
            rem_reg <= ge ? rem_reg - dvs_reg : rem_reg;
            dvs_reg <= dvs_reg >> 1;
            q_reg   <= {q_reg[6:0], ge};
        end
    end

    assign busy = busy_reg;
    assign quot = q_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/rgb_box_blur_11x11.sv -----
// Top level of the streaming RGB box blur with a chain of column-sum cells.
// A pixel transaction that yields no result is written to the line store and s_ready stays high;
// after one that yields a result, the next pixel waits while the sequencer reads columns,
// divides and loads the output: the first result of a row reads RADIUS+1 columns, others one.
// The wait is set by the single line-store read port and the bit-serial divider.
// Reset (synchronous, active low) clears all position counters and restores 640 x 480;
// the line store is not cleared, entries are read only after being written.
`default_nettype none

module rgb_box_blur_11x11
    import rbb_pkg::*;
#(
    parameter int RADIUS    = RADIUS_DEF,
    parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire rbb_in_t              s_data,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output rbb_out_t                  m_data,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data
);

    localparam int SR     = 2 * RADIUS + 2;
    localparam int SLOT_W = $clog2(SR);
    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int XW     = ((COL_W > FW_W) ? COL_W : FW_W) + 1;
    localparam int RW     = ROW_W + 2;
    localparam int DEPTH  = SR * MAX_WIDTH;
    localparam int AW     = $clog2(DEPTH);
    localparam int WIN    = 2 * RADIUS + 1;
    localparam int NW     = $clog2(WIN + 1);
    localparam int CS_W   = $clog2(WIN * 255 + 1);
    localparam int SUM_W  = $clog2(WIN * WIN * 255 + 1);
    localparam int CNT_W  = $clog2(WIN * WIN + 1);

    rbb_state_t state_reg, state_next;

    logic [FW_W-1:0]   fw_reg;
    logic [FH_W-1:0]   fh_reg;
    logic [COL_W-1:0]  in_col_reg, out_col_reg;
    logic [ROW_W-1:0]  in_row_reg, out_row_reg;
    logic [SLOT_W-1:0] in_slot_reg, out_slot_reg;
    logic              done_reg;

    logic [SLOT_W-1:0] r0slot_reg, rd_slot_reg;
    logic [NW-1:0]     nrows_reg, ncols_reg, iss_reg, pushes_reg;
    logic [XW-1:0]     pcol_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              rvalid_reg;

    logic [2:0][CS_W-1:0]  acc_reg;
    logic [2:0][SUM_W-1:0] total_reg;
    logic [2:0][CS_W-1:0]  chain_q [WIN];
    logic [23:0]           rdata;

    rbb_out_t out_reg;
    logic     m_valid_reg;

    // Control outputs of the sequencer.
    logic ram_we, col_issue, chain_clr, chain_shift, div_start, out_load;

    // Effective frame size.
    logic [XW-1:0] fw_x, w_x;
    logic [RW-1:0] fh_x, h_x;
    assign fw_x = XW'(fw_reg);
    assign fh_x = RW'(fh_reg);
    assign w_x  = (fw_x == '0) ? XW'(1) : ((fw_x > XW'(MAX_WIDTH)) ? XW'(MAX_WIDTH) : fw_x);
    assign h_x  = (fh_x == '0) ? RW'(1) : ((fh_x > RW'(MAX_HEIGHT)) ? RW'(MAX_HEIGHT) : fh_x);

    // Input position update.
    logic [XW-1:0] in_col_inc;
    logic [RW-1:0] in_row_inc;
    logic          col_wrap, row_wrap;
    assign in_col_inc = XW'(in_col_reg) + XW'(1);
    assign in_row_inc = RW'(in_row_reg) + RW'(1);
    assign col_wrap   = in_col_inc >= w_x;
    assign row_wrap   = col_wrap && (in_row_inc >= h_x);

    // Bottom-right corner of the next result's window.
    logic [RW-1:0] orow_p, tr;
    logic [XW-1:0] ocol_p, tc;
    logic          win_ready;
    assign orow_p    = RW'(out_row_reg) + RW'(RADIUS);
    assign ocol_p    = XW'(out_col_reg) + XW'(RADIUS);
    assign tr        = (orow_p < h_x - RW'(1)) ? orow_p : h_x - RW'(1);
    assign tc        = (ocol_p < w_x - XW'(1)) ? ocol_p : w_x - XW'(1);
    assign win_ready = (tr < RW'(in_row_reg)) ||
                       ((tr == RW'(in_row_reg)) && (tc <= XW'(in_col_reg)));

    logic pix_acc, go_emit;
    assign pix_acc = (state_reg == ST_IDLE) && s_valid && !done_reg && (s_data.op == OP_PIXEL);
    assign go_emit = done_reg || ((s_data.op == OP_PIXEL) && (row_wrap || win_ready));

    // Window bounds of the next result.
    logic [SLOT_W-1:0] rb, r0slot;
    logic [RW-1:0]     r0;
    logic [XW-1:0]     c0;
    logic              row_top;
    assign row_top = out_row_reg >= ROW_W'(RADIUS);
    assign rb      = row_top ? SLOT_W'(RADIUS) : SLOT_W'(out_row_reg);
    assign r0slot  = (out_slot_reg >= rb) ? out_slot_reg - rb :
                     SLOT_W'({1'b0, out_slot_reg} + (SLOT_W + 1)'(SR) - {1'b0, rb});
    assign r0      = RW'(out_row_reg) - RW'(rb);
    assign c0      = (out_col_reg >= COL_W'(RADIUS)) ? XW'(out_col_reg) - XW'(RADIUS) : '0;

    logic last_out;
    assign last_out = (RW'(out_row_reg) == h_x - RW'(1)) && (XW'(out_col_reg) == w_x - XW'(1));

    logic col_out;
    assign col_out = pcol_reg >= w_x;

    logic [SLOT_W-1:0] rd_slot_inc;
    assign rd_slot_inc = (rd_slot_reg == SLOT_W'(SR - 1)) ? '0 : rd_slot_reg + SLOT_W'(1);

    // Line store.
    logic [AW-1:0] waddr, raddr;
    assign waddr = AW'(in_slot_reg) * AW'(MAX_WIDTH) + AW'(in_col_reg);
    assign raddr = AW'(rd_slot_reg) * AW'(MAX_WIDTH) + AW'(pcol_reg[COL_W-1:0]);

    rbb_ram #(
        .WIDTH(24),
        .DEPTH(DEPTH)
    ) u_store (
        .clk  (aclk),
        .we   (ram_we),
        .waddr(waddr),
        .wdata({s_data.red_in, s_data.green_in, s_data.blue_in}),
        .raddr(raddr),
        .rdata(rdata)
    );

    // Chain of column-sum cells; the last cell holds the column leaving the window.
    genvar k;
    generate
        for (k = 0; k < WIN; k++) begin : g_chain
            if (k == 0) begin : g_head
                rbb_cell #(.CS_W(CS_W)) u_cell (
                    .clk(aclk), .clear(chain_clr), .shift(chain_shift),
                    .d_in(acc_reg), .q(chain_q[k])
                );
            end else begin : g_body
                rbb_cell #(.CS_W(CS_W)) u_cell (
                    .clk(aclk), .clear(chain_clr), .shift(chain_shift),
                    .d_in(chain_q[k-1]), .q(chain_q[k])
                );
            end
        end
    endgenerate

    // Dividers, one per channel, running in lockstep.
    logic [2:0]      div_busy;
    logic [2:0][7:0] quot;
    genvar ch;
    generate
        for (ch = 0; ch < 3; ch++) begin : g_div
            rbb_div #(.SUM_W(SUM_W), .CNT_W(CNT_W)) u_div (
                .clk  (aclk),
                .rstn (aresetn),
                .start(div_start),
                .sum  (total_reg[ch]),
                .cnt  (cnt_reg),
                .busy (div_busy[ch]),
                .quot (quot[ch])
            );
        end
    endgenerate

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:   if (s_valid && go_emit) state_next = ST_PREP;
            ST_PREP:   state_next = ST_COL;
            ST_COL: begin
                if (col_out) begin
                    state_next = ST_PUSH;
                end else if (iss_reg == nrows_reg - NW'(1)) begin
                    state_next = ST_CWAIT;
                end
            end
            ST_CWAIT:  state_next = ST_PUSH;
            ST_PUSH:   state_next = (pushes_reg == NW'(1)) ? ST_DSTART : ST_COL;
            ST_DSTART: state_next = ST_DIV;
            ST_DIV:    if (!div_busy[0]) state_next = ST_OUT;
            ST_OUT:    if (!m_valid_reg || m_ready) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // Sequencer outputs.
    always_comb begin
        s_ready     = 1'b0;
        ram_we      = 1'b0;
        col_issue   = 1'b0;
        chain_clr   = 1'b0;
        chain_shift = 1'b0;
        div_start   = 1'b0;
        out_load    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                ram_we  = pix_acc;
            end
            ST_PREP:   chain_clr   = (out_col_reg == '0);
            ST_COL:    col_issue   = !col_out;
            ST_PUSH:   chain_shift = 1'b1;
            ST_DSTART: div_start   = 1'b1;
            ST_OUT:    out_load    = !m_valid_reg || m_ready;
            default: begin
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            fw_reg       <= FW_W'(WIDTH_RESET);
            fh_reg       <= FH_W'(HEIGHT_RESET);
            in_col_reg   <= '0;
            in_row_reg   <= '0;
            in_slot_reg  <= '0;
            out_col_reg  <= '0;
            out_row_reg  <= '0;
            out_slot_reg <= '0;
            done_reg     <= 1'b0;
            rvalid_reg   <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg  <= state_next;
            rvalid_reg <= col_issue;
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (cfg_we) begin
                // A write to the frame width or height register restarts the frame.
                if (cfg_index == REG_FRAME_WIDTH) begin
                    fw_reg <= cfg_data[FW_W-1:0];
                end else if (cfg_index == REG_FRAME_HEIGHT) begin
                    fh_reg <= cfg_data[FH_W-1:0];
                end
                if (cfg_index == REG_FRAME_WIDTH || cfg_index == REG_FRAME_HEIGHT) begin
                    in_col_reg   <= '0;
                    in_row_reg   <= '0;
                    in_slot_reg  <= '0;
                    out_col_reg  <= '0;
                    out_row_reg  <= '0;
                    out_slot_reg <= '0;
                    done_reg     <= 1'b0;
                end
            end else if (out_load) begin
                if (last_out) begin
                    in_col_reg   <= '0;
                    in_row_reg   <= '0;
                    in_slot_reg  <= '0;
                    out_col_reg  <= '0;
                    out_row_reg  <= '0;
                    out_slot_reg <= '0;
                    done_reg     <= 1'b0;
                end else if (XW'(out_col_reg) + XW'(1) >= w_x) begin
                    out_col_reg  <= '0;
                    out_row_reg  <= out_row_reg + ROW_W'(1);
                    out_slot_reg <= (out_slot_reg == SLOT_W'(SR - 1)) ? '0 :
                                    out_slot_reg + SLOT_W'(1);
                end else begin
                    out_col_reg <= out_col_reg + COL_W'(1);
                end
            end else if (pix_acc) begin
                if (row_wrap) begin
                    in_col_reg  <= '0;
                    in_row_reg  <= '0;
                    in_slot_reg <= '0;
                    done_reg    <= 1'b1;
                end else if (col_wrap) begin
                    in_col_reg  <= '0;
                    in_row_reg  <= in_row_reg + ROW_W'(1);
                    in_slot_reg <= (in_slot_reg == SLOT_W'(SR - 1)) ? '0 :
                                   in_slot_reg + SLOT_W'(1);
                end else begin
                    in_col_reg <= in_col_reg + COL_W'(1);
                end
            end
        end
    end

    // Window datapath.
    always_ff @(posedge aclk) begin
        cnt_reg <= CNT_W'(nrows_reg) * CNT_W'(ncols_reg);
        if (rvalid_reg) begin
            acc_reg[2] <= acc_reg[2] + CS_W'(rdata[23:16]);
            acc_reg[1] <= acc_reg[1] + CS_W'(rdata[15:8]);
            acc_reg[0] <= acc_reg[0] + CS_W'(rdata[7:0]);
        end
        case (state_reg)
            ST_PREP: begin
                r0slot_reg  <= r0slot;
                rd_slot_reg <= r0slot;
                iss_reg     <= '0;
                acc_reg     <= '0;
                nrows_reg   <= NW'(tr - r0 + RW'(1));
                ncols_reg   <= NW'(tc - c0 + XW'(1));
                if (out_col_reg == '0) begin
                    pcol_reg   <= '0;
                    pushes_reg <= NW'(RADIUS + 1);
                    total_reg  <= '0;
                end else begin
                    pcol_reg   <= ocol_p;
                    pushes_reg <= NW'(1);
                end
            end
            ST_COL: begin
                if (!col_out) begin
                    rd_slot_reg <= rd_slot_inc;
                    iss_reg     <= iss_reg + NW'(1);
                end
            end
            ST_PUSH: begin
                for (int i = 0; i < 3; i++) begin
                    total_reg[i] <= total_reg[i] + SUM_W'(acc_reg[i]) -
                                    SUM_W'(chain_q[WIN-1][i]);
                end
                acc_reg     <= '0;
                rd_slot_reg <= r0slot_reg;
                iss_reg     <= '0;
                pcol_reg    <= pcol_reg + XW'(1);
                pushes_reg  <= pushes_reg - NW'(1);
            end
            default: begin
            end
        endcase
        if (out_load) begin
            out_reg.red_out   <= quot[2];
            out_reg.green_out <= quot[1];
            out_reg.blue_out  <= quot[0];
            out_reg.frame_end <= last_out;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

    // A divide never starts with an empty window.
    a_cnt_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DSTART) |-> (cnt_reg != '0))
        else $error("window count is zero at divide start");

    // Read data is only accumulated in the cycle after a line-store read was issued.
    a_read_order: assert property (@(posedge aclk) disable iff (!aresetn)
        rvalid_reg |-> ($past(state_reg) == ST_COL))
        else $error("read data without a preceding read");

    // The last result of a frame returns all position counters to the frame start.
    a_frame_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_load && last_out && !cfg_we) |=>
            (out_row_reg == '0 && out_col_reg == '0 && !done_reg && in_row_reg == '0))
        else $error("frame did not restart after its last result");

endmodule

`default_nettype wire
